### rtl/jse_pkg.sv
package jse_pkg;

    typedef logic [3:0][7:0] win_t;

    typedef enum logic [1:0] {
        K_ASCII = 2'd0,
        K_FFFD  = 2'd1,
        K_PASS  = 2'd2,
        K_HOLD  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] ecnt;
        logic [2:0] cons;
    } scan_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    localparam logic [7:0]  BSLASH    = 8'h5C;
    localparam logic [7:0]  CTRL_TOP  = 8'h20;
    localparam logic [47:0] FFFD_TEXT = "\\ufffd";
    localparam logic [2:0]  FFFD_LEN  = 3'd6;
    localparam logic [2:0]  LONG_LEN  = 3'd6;
    localparam logic [2:0]  SHORT_LEN = 3'd2;

    function automatic logic [7:0] short_code(logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h22:   r = 8'h22;
            8'h5C:   r = 8'h5C;
            8'h08:   r = 8'h62;
            8'h0C:   r = 8'h66;
            8'h0A:   r = 8'h6E;
            8'h0D:   r = 8'h72;
            8'h09:   r = 8'h74;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] ascii_len(logic [7:0] c);
        logic [2:0] r;
        if (short_code(c) != 8'h00)
            r = SHORT_LEN;
        else if (c < CTRL_TOP)
            r = LONG_LEN;
        else
            r = 3'd1;
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = 8'(8'h30 + {4'b0, v});
        else
            r = 8'(8'h57 + {4'b0, v});
        return r;
    endfunction

    function automatic logic [7:0] text_byte(kind_t kind, logic [7:0] c, logic [2:0] idx);
        logic [7:0] r;
        logic [7:0] sc;
        sc = short_code(c);
        r  = c;
        if (kind == K_FFFD) begin
            r = FFFD_TEXT[8 * (5 - int'(idx)) +: 8];
        end
        else if (sc != 8'h00) begin
            r = (idx == 3'd0) ? BSLASH : sc;
        end
        else if (c < CTRL_TOP) begin
            case (idx)
                3'd0:    r = BSLASH;
                3'd1:    r = 8'h75;
                3'd2:    r = 8'h30;
                3'd3:    r = 8'h30;
                3'd4:    r = hex_digit(c[7:4]);
                default: r = hex_digit(c[3:0]);
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/jse_if.sv
interface jse_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

interface jse_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       none_emitted;

    modport source (output valid, output out_byte, output run_last, output none_emitted,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input none_emitted,
                  output ready);
endinterface

### rtl/jse_scan.sv
module jse_scan (
    input  jse_pkg::win_t  win,
    input  logic [2:0]     avail,
    input  logic           str_end,
    output jse_pkg::scan_t res
);

    logic [7:0]  b;
    logic [2:0]  len;
    logic [2:0]  lim;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] cp_min;

    assign b = win[0];

    always_comb
    begin
        if (b < 8'h80)
            len = 3'd1;
        else if ((b & 8'hE0) == 8'hC0)
            len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)
            len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)
            len = 3'd4;
        else
            len = 3'd0;
    end

    always_comb
    begin
        lim = (avail < len) ? avail : len;
        bad = 1'b0;
        for (int k = 1; k < 4; k++) begin
            if (3'(k) < lim && win[k][7:6] != 2'b10)
                bad = 1'b1;
        end

        case (len)
            3'd2: begin
                cp     = {10'b0, b[4:0], win[1][5:0]};
                cp_min = 21'h80;
            end
            3'd3: begin
                cp     = {5'b0, b[3:0], win[1][5:0], win[2][5:0]};
                cp_min = 21'h800;
            end
            default: begin
                cp     = {b[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
                cp_min = 21'h10000;
            end
        endcase

        res.kind = jse_pkg::K_PASS;
        res.ecnt = len;
        res.cons = len;
        if (b < 8'h80) begin
            res.kind = jse_pkg::K_ASCII;
            res.ecnt = jse_pkg::ascii_len(b);
            res.cons = 3'd1;
        end
        else if (len == 3'd0) begin
            res.kind = jse_pkg::K_FFFD;
            res.ecnt = jse_pkg::FFFD_LEN;
            res.cons = 3'd1;
        end
        else begin
            if (!bad && avail < len) begin
                if (!str_end)
                    res.kind = jse_pkg::K_HOLD;
                else
                    bad = 1'b1;
            end
            if (!bad && avail >= len) begin
                if (cp < cp_min || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
                    bad = 1'b1;
            end
            if (bad) begin
                res.kind = jse_pkg::K_FFFD;
                res.ecnt = jse_pkg::FFFD_LEN;
                res.cons = 3'd1;
            end
        end
    end

endmodule

### rtl/json_string_escaper_utf8_unit.sv
// JSON string escaper with UTF-8 validation.
// req carries one raw string byte per request with string_end on the final
// byte; rsp carries the escaped text one byte per request, run_last marking
// the last byte caused by a request, none_emitted marking a request that was
// only buffered (one rsp request with out_byte zero).
// A request is taken only in the idle state. The sequencer then runs one
// shared scan unit over the queue of held bytes plus the new byte: a scan
// per unit, one emit step per escaped byte, a closing scan and a flush.
// There are at most four units per request, so four six-byte escapes can
// come from one request. Output bytes are delayed by one stage so run_last
// is known; the last byte leaves during the flush cycle. A stalled rsp holds
// the output register and stalls the sequencer whenever it has a byte to
// push; req stays low meanwhile.
// Reset clears the state, the held count and the pending and output valid
// flags; nothing is held.
module json_string_escaper_utf8_unit (
    input  logic       clk,
    input  logic       rst_n,
    jse_req_if.sink    req,
    jse_rsp_if.source  rsp
);

    jse_pkg::state_t  state_reg, state_next;
    logic [7:0]       q_reg [4];
    logic [7:0]       q_next [4];
    logic [1:0]       held_cnt_reg, held_cnt_next;
    logic [2:0]       n_reg, n_next;
    logic [2:0]       pos_reg, pos_next;
    logic             end_reg, end_next;
    jse_pkg::kind_t   kind_reg, kind_next;
    logic [2:0]       ecnt_reg, ecnt_next;
    logic [2:0]       cons_reg, cons_next;
    logic [2:0]       idx_reg, idx_next;
    logic [7:0]       lead_reg, lead_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_none_reg, out_none_next;

    jse_pkg::win_t    win;
    logic [2:0]       avail;
    logic [2:0]       rem;
    jse_pkg::scan_t   scan;
    logic [7:0]       emit_byte;
    logic             out_free;
    logic             push;
    logic [7:0]       push_byte;
    logic             push_last;
    logic             push_none;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            win[k] = q_reg[pos_reg[1:0] + 2'(k)];
    end

    assign avail = n_reg - pos_reg;
    assign rem   = n_reg - pos_reg;

    jse_scan u_scan (
        .win     (win),
        .avail   (avail),
        .str_end (end_reg),
        .res     (scan)
    );

    assign emit_byte = (kind_reg == jse_pkg::K_PASS)
                       ? q_reg[pos_reg[1:0] + idx_reg[1:0]]
                       : jse_pkg::text_byte(kind_reg, lead_reg, idx_reg);

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        q_next          = q_reg;
        held_cnt_next   = held_cnt_reg;
        n_next          = n_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        kind_next       = kind_reg;
        ecnt_next       = ecnt_reg;
        cons_next       = cons_reg;
        idx_next        = idx_reg;
        lead_next       = lead_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        push            = 1'b0;
        push_byte       = pend_byte_reg;
        push_last       = 1'b0;
        push_none       = 1'b0;

        case (state_reg)
            jse_pkg::ST_IDLE: begin
                if (req.valid) begin
                    q_next[held_cnt_reg] = req.in_byte;
                    n_next          = {1'b0, held_cnt_reg} + 3'd1;
                    pos_next        = 3'd0;
                    end_next        = req.string_end;
                    pend_valid_next = 1'b0;
                    state_next      = jse_pkg::ST_SCAN;
                end
            end
            jse_pkg::ST_SCAN: begin
                if (pos_reg == n_reg || scan.kind == jse_pkg::K_HOLD) begin
                    for (int i = 0; i < 3; i++)
                        q_next[i] = q_reg[pos_reg[1:0] + 2'(i)];
                    held_cnt_next = rem[1:0];
                    state_next    = jse_pkg::ST_FLUSH;
                end
                else begin
                    kind_next  = scan.kind;
                    ecnt_next  = scan.ecnt;
                    cons_next  = scan.cons;
                    lead_next  = win[0];
                    idx_next   = 3'd0;
                    state_next = jse_pkg::ST_EMIT;
                end
            end
            jse_pkg::ST_EMIT: begin
                if (!pend_valid_reg || out_free) begin
                    push            = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_byte_next  = emit_byte;
                    if (idx_reg == ecnt_reg - 3'd1) begin
                        pos_next   = pos_reg + cons_reg;
                        state_next = jse_pkg::ST_SCAN;
                    end
                    else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            jse_pkg::ST_FLUSH: begin
                if (out_free) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    push_none       = !pend_valid_reg;
                    push_byte       = pend_valid_reg ? pend_byte_reg : 8'h00;
                    pend_valid_next = 1'b0;
                    state_next      = jse_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_none_next  = out_none_reg;
        if (push) begin
            out_valid_next = 1'b1;
            out_byte_next  = push_byte;
            out_last_next  = push_last;
            out_none_next  = push_none;
        end
        else if (rsp.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= jse_pkg::ST_IDLE;
            held_cnt_reg   <= 2'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            held_cnt_reg   <= held_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        n_reg         <= n_next;
        pos_reg       <= pos_next;
        end_reg       <= end_next;
        kind_reg      <= kind_next;
        ecnt_reg      <= ecnt_next;
        cons_reg      <= cons_next;
        idx_reg       <= idx_next;
        lead_reg      <= lead_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_none_reg  <= out_none_next;
    end

    assign req.ready        = (state_reg == jse_pkg::ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.out_byte     = out_byte_reg;
    assign rsp.run_last     = out_last_reg;
    assign rsp.none_emitted = out_none_reg;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    logic clk = 1'b0;
    logic rst_n;
    int   send_pct;
    int   recv_pct;
    int   items_sent;
    int   cycle_count;

    localparam int CYCLE_LIMIT = 400000;

    jse_req_if req_ch ();
    jse_rsp_if rsp_ch ();

    json_string_escaper_utf8_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    class escape_board;
        typedef struct packed {
            logic [7:0] out_byte;
            logic       run_last;
            logic       none_emitted;
        } text_byte_t;

        text_byte_t  expected_text[$];
        logic [7:0]  step_text[$];
        logic [7:0]  held[3];
        int unsigned held_cnt;
        int          errors;

        function new();
            held_cnt = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        function int seq_len(logic [7:0] lead);
            if (lead < 8'h80)
                return 1;
            if (lead[7:5] == 3'b110)
                return 2;
            if (lead[7:4] == 4'b1110)
                return 3;
            if (lead[7:3] == 5'b11110)
                return 4;
            return 0;
        endfunction

        function void add_text(logic [7:0] c);
            step_text = {step_text, c};
        endfunction

        function void put_pair(logic [7:0] c);
            add_text(8'h5C);
            add_text(c);
        endfunction

        function void put_fffd();
            string s;
            s = "\\ufffd";
            for (int i = 0; i < s.len(); i++)
                add_text(s[i]);
        endfunction

        function logic [7:0] hex_lower(logic [3:0] v);
            return (v < 4'd10) ? 8'(8'h30 + v) : 8'(8'h61 + v - 4'd10);
        endfunction

        function void put_ascii(logic [7:0] c);
            case (c)
                8'h22:   put_pair(8'h22);
                8'h5C:   put_pair(8'h5C);
                8'h08:   put_pair("b");
                8'h0C:   put_pair("f");
                8'h0A:   put_pair("n");
                8'h0D:   put_pair("r");
                8'h09:   put_pair("t");
                default:
                begin
                    if (c < 8'h20) begin
                        put_pair("u");
                        add_text("0");
                        add_text("0");
                        add_text(hex_lower(c[7:4]));
                        add_text(hex_lower(c[3:0]));
                    end
                    else begin
                        add_text(c);
                    end
                end
            endcase
        endfunction

        // note an accepted request and queue the bytes it must produce
        function void note_request(logic [7:0] b, logic string_end);
            logic [7:0]  q[$];
            int          pos;
            int          avail;
            int          len;
            int          lim;
            int          rem;
            bit          bad;
            int unsigned cp;
            int unsigned lowest;
            text_byte_t  t;

            step_text = {};
            for (int i = 0; i < held_cnt; i++)
                q = {q, held[i]};
            q = {q, b};
            pos = 0;
            while (pos < q.size()) begin
                avail = q.size() - pos;
                if (q[pos] < 8'h80) begin
                    put_ascii(q[pos]);
                    pos++;
                    continue;
                end
                len = seq_len(q[pos]);
                if (len == 0) begin
                    put_fffd();
                    pos++;
                    continue;
                end
                lim = (avail < len) ? avail : len;
                bad = 1'b0;
                for (int k = 1; k < lim; k++)
                    if (q[pos + k][7:6] != 2'b10)
                        bad = 1'b1;
                if (!bad && avail < len) begin
                    if (!string_end)
                        break;
                    bad = 1'b1;
                end
                if (!bad) begin
                    case (len)
                        2:       begin cp = q[pos] & 8'h1F; lowest = 32'h80;    end
                        3:       begin cp = q[pos] & 8'h0F; lowest = 32'h800;   end
                        default: begin cp = q[pos] & 8'h07; lowest = 32'h10000; end
                    endcase
                    for (int k = 1; k < len; k++)
                        cp = (cp << 6) | (q[pos + k] & 8'h3F);
                    if (cp < lowest || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF))
                        bad = 1'b1;
                end
                if (bad) begin
                    put_fffd();
                    pos++;
                end
                else begin
                    for (int k = 0; k < len; k++)
                        add_text(q[pos + k]);
                    pos += len;
                end
            end

            rem = q.size() - pos;
            if (rem > 3)
                rem = 3;
            for (int i = 0; i < rem; i++)
                held[i] = q[pos + i];
            held_cnt = rem;

            if (step_text.size() == 0) begin
                t = '{out_byte: 8'h00, run_last: 1'b1, none_emitted: 1'b1};
                expected_text = {expected_text, t};
            end
            else begin
                foreach (step_text[i]) begin
                    t = '{out_byte: step_text[i], run_last: (i == step_text.size() - 1),
                          none_emitted: 1'b0};
                    expected_text = {expected_text, t};
                end
            end
        endfunction

        function void check_result(logic [7:0] ob, logic rl, logic ne);
            text_byte_t want;
            if (expected_text.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected rsp: out_byte %h run_last %b none_emitted %b",
                             ob, rl, ne);
                return;
            end
            want = expected_text.pop_front();
            if (want.out_byte !== ob || want.run_last !== rl || want.none_emitted !== ne) begin
                errors++;
                if (errors <= 10)
                    $display("rsp mismatch: exp %h/%b/%b got %h/%b/%b",
                             want.out_byte, want.run_last, want.none_emitted, ob, rl, ne);
            end
        endfunction
    endclass

    escape_board board = new();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic string_end);
        if ($urandom_range(99) < send_pct) begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.in_byte    <= b;
        req_ch.string_end <= string_end;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(b, string_end);
        items_sent++;
    endtask

    function automatic logic [7:0] random_ascii();
        case ($urandom_range(3))
            0:
            begin
                case ($urandom_range(6))
                    0:       return 8'h22;
                    1:       return 8'h5C;
                    2:       return 8'h08;
                    3:       return 8'h0C;
                    4:       return 8'h0A;
                    5:       return 8'h0D;
                    default: return 8'h09;
                endcase
            end
            1:       return 8'($urandom_range(31));
            default: return 8'($urandom_range(127));
        endcase
    endfunction

    // mostly well-formed UTF-8 with random content, some noise and broken sequences
    task automatic send_random_group();
        logic [7:0]  seq[4];
        int          len;
        int          pick;
        int unsigned cp;

        pick = $urandom_range(99);
        if (pick < 30) begin
            len = 1;
            seq[0] = random_ascii();
        end
        else if (pick < 80) begin
            case ($urandom_range(2))
                0:       cp = $urandom_range(32'h7FF, 32'h80);
                1:       cp = $urandom_range(32'hFFFF, 32'h800);
                default: cp = $urandom_range(32'h10FFFF, 32'h10000);
            endcase
            if (cp < 32'h800) begin
                len = 2;
                seq[0] = 8'hC0 | 8'(cp >> 6);
            end
            else if (cp < 32'h10000) begin
                len = 3;
                seq[0] = 8'hE0 | 8'(cp >> 12);
            end
            else begin
                len = 4;
                seq[0] = 8'hF0 | 8'(cp >> 18);
            end
            for (int k = 1; k < len; k++)
                seq[k] = 8'h80 | 8'((cp >> (6 * (len - 1 - k))) & 32'h3F);
        end
        else if (pick < 90) begin
            len = 1;
            seq[0] = 8'($urandom_range(255));
        end
        else begin
            seq[0] = 8'($urandom_range(8'hF7, 8'hC0));
            len = (seq[0] >= 8'hF0) ? 4 : (seq[0] >= 8'hE0) ? 3 : 2;
            for (int k = 1; k < len; k++)
                seq[k] = 8'h80 | 8'($urandom_range(63));
            if ($urandom_range(3) == 0)
                seq[$urandom_range(len - 1, 1)] = 8'($urandom_range(255));
        end
        for (int k = 0; k < len; k++)
            send_byte(seq[k], $urandom_range(11) == 0);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("json_string_escaper_utf8_unit verification failed");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.out_byte, rsp_ch.run_last, rsp_ch.none_emitted);
            rsp_ch.ready <= ($urandom_range(99) >= recv_pct);
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.in_byte    = 8'h00;
        req_ch.string_end = 1'b0;
        send_pct          = 38;
        recv_pct          = 58;
        items_sent        = 0;
        cycle_count       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ASCII escapes and extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h5C, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h7F, 1'b0);
        // valid 2- and 4-byte sequences
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // surrogate
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        // overlong
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // above 10FFFF, four replacements from one request
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // early rejection, bad lead, cut off by string end
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC3, 1'b1);

        while (items_sent < 120)
            send_random_group();
        send_pct = 58;
        recv_pct = 38;
        while (items_sent < 215)
            send_random_group();
        send_pct = 0;
        recv_pct = 0;
        while (items_sent < 310)
            send_random_group();
        req_ch.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("json_string_escaper_utf8_unit verification clean");
        else
            $display("json_string_escaper_utf8_unit verification failed");
        $finish;
    end

endmodule
